// ----- hdl/asgr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the SGR escape decoder.
// Depends on nothing; every other file of the block uses it.
package asgr_pkg;

	// Bytes that the parser looks for.
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_FIVE   = 8'h35;

	// SGR parameter codes with a meaning of their own.
	localparam logic [15:0] SGR_RESET     = 16'd0;
	localparam logic [15:0] SGR_BOLD      = 16'd1;
	localparam logic [15:0] SGR_DIM       = 16'd2;
	localparam logic [15:0] SGR_ITALIC    = 16'd3;
	localparam logic [15:0] SGR_UNDERLINE = 16'd4;
	localparam logic [15:0] SGR_BLINK     = 16'd5;
	localparam logic [15:0] SGR_REVERSE   = 16'd7;
	localparam logic [15:0] SGR_NO_BOLD   = 16'd21;
	localparam logic [15:0] SGR_NORMAL    = 16'd22;
	localparam logic [15:0] SGR_NO_ITALIC = 16'd23;
	localparam logic [15:0] SGR_NO_UNDER  = 16'd24;
	localparam logic [15:0] SGR_NO_BLINK  = 16'd25;
	localparam logic [15:0] SGR_NO_REV    = 16'd27;
	localparam logic [15:0] SGR_FG_BASE   = 16'd30;
	localparam logic [15:0] SGR_FG_LAST   = 16'd37;
	localparam logic [15:0] SGR_FG_EXT    = 16'd38;
	localparam logic [15:0] SGR_FG_DEF    = 16'd39;
	localparam logic [15:0] SGR_BG_BASE   = 16'd40;
	localparam logic [15:0] SGR_BG_LAST   = 16'd47;
	localparam logic [15:0] SGR_BG_EXT    = 16'd48;
	localparam logic [15:0] SGR_BG_DEF    = 16'd49;
	localparam logic [15:0] SGR_FGB_BASE  = 16'd90;
	localparam logic [15:0] SGR_FGB_LAST  = 16'd97;
	localparam logic [15:0] SGR_BGB_BASE  = 16'd100;
	localparam logic [15:0] SGR_BGB_LAST  = 16'd107;

	// Attribute bit positions.
	localparam int unsigned ATTR_BOLD      = 0;
	localparam int unsigned ATTR_DIM       = 1;
	localparam int unsigned ATTR_ITALIC    = 2;
	localparam int unsigned ATTR_UNDERLINE = 3;
	localparam int unsigned ATTR_BLINK     = 4;
	localparam int unsigned ATTR_REVERSE   = 5;

	// Phases of an extended color parameter (38;5;n or 48;5;n).
	localparam logic [1:0] EXT_NONE     = 2'd0;
	localparam logic [1:0] EXT_WANT_5   = 2'd1;
	localparam logic [1:0] EXT_WANT_SEP = 2'd2;
	localparam logic [1:0] EXT_INDEX    = 2'd3;

	// Configuration port.
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ENABLE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_COLORS = 4'd1;

	// Attributes and colors, live or shadow.
	typedef struct packed {
		logic [5:0] attr;
		logic [4:0] fg;
		logic [4:0] bg;
	} attr_set_t;

	// Progress through an extended color and the stop flag.
	typedef struct packed {
		logic [1:0] phase;
		logic       is_bg;
		logic       stopped;
	} ext_state_t;

	// One result beat.
	typedef struct packed {
		logic       text_valid;
		logic [7:0] text_byte;
		logic [5:0] attr_bits;
		logic [4:0] fg_index;
		logic [4:0] bg_index;
		logic [8:0] color_pair;
	} result_t;

endpackage

// ----- hdl/asgr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for bytes, results and configuration writes.
// Depends on asgr_pkg for the configuration field widths.
interface asgr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface asgr_res_if;
	logic       valid;
	logic       ready;
	logic       text_valid;
	logic [7:0] text_byte;
	logic [5:0] attr_bits;
	logic [4:0] fg_index;
	logic [4:0] bg_index;
	logic [8:0] color_pair;

	modport source (output valid, output text_valid, output text_byte, output attr_bits,
		output fg_index, output bg_index, output color_pair, input ready);
	modport sink (input valid, input text_valid, input text_byte, input attr_bits,
		input fg_index, input bg_index, input color_pair, output ready);
endinterface

interface asgr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [asgr_pkg::CFG_IDX_W-1:0] index;
	logic [asgr_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/asgr_param_unit.sv -----
`timescale 1ns / 1ps
// Applies one completed SGR parameter to the shadow attributes and colors.
// Depends on asgr_pkg; purely combinational, used by asgr_parser.
module asgr_param_unit (
	input  logic [15:0]          param_value,
	input  logic                 is_semicolon,
	input  logic                 bright_colors,
	input  asgr_pkg::attr_set_t  shadow,
	input  asgr_pkg::ext_state_t ext,
	output asgr_pkg::attr_set_t  shadow_next,
	output asgr_pkg::ext_state_t ext_next
);
	import asgr_pkg::*;

	// Color candidates for each color range.
	logic [15:0] fg_norm, bg_norm, fg_brt, bg_brt, fg_fold, bg_fold;
	logic [15:0] ext_brt, ext_fold;

	always_comb begin
		fg_norm  = param_value - 16'd29;
		bg_norm  = param_value - 16'd39;
		fg_brt   = param_value - 16'd81;
		bg_brt   = param_value - 16'd91;
		fg_fold  = param_value - 16'd89;
		bg_fold  = param_value - 16'd99;
		ext_brt  = param_value + 16'd1;
		ext_fold = param_value - 16'd7;
	end

	// End-of-parameter handling: plain codes, or a step of an extended color.
	always_comb begin
		logic stop;
		stop        = 1'b0;
		shadow_next = shadow;
		ext_next    = ext;
		if (!ext.stopped) begin
			case (ext.phase)
				EXT_NONE: begin
					if (param_value == SGR_FG_EXT || param_value == SGR_BG_EXT) begin
						ext_next.is_bg = (param_value == SGR_BG_EXT);
						if (is_semicolon) begin
							ext_next.phase = EXT_WANT_5;
						end else begin
							stop = 1'b1;
						end
					end else begin
						case (param_value) inside
							SGR_RESET: shadow_next = '0;
							SGR_BOLD: shadow_next.attr[ATTR_BOLD] = 1'b1;
							SGR_DIM: shadow_next.attr[ATTR_DIM] = 1'b1;
							SGR_ITALIC: shadow_next.attr[ATTR_ITALIC] = 1'b1;
							SGR_UNDERLINE: shadow_next.attr[ATTR_UNDERLINE] = 1'b1;
							SGR_BLINK: shadow_next.attr[ATTR_BLINK] = 1'b1;
							SGR_REVERSE: shadow_next.attr[ATTR_REVERSE] = 1'b1;
							SGR_NO_BOLD: shadow_next.attr[ATTR_BOLD] = 1'b0;
							SGR_NORMAL: begin
								shadow_next.attr[ATTR_BOLD] = 1'b0;
								shadow_next.attr[ATTR_DIM]  = 1'b0;
							end
							SGR_NO_ITALIC: shadow_next.attr[ATTR_ITALIC] = 1'b0;
							SGR_NO_UNDER: shadow_next.attr[ATTR_UNDERLINE] = 1'b0;
							SGR_NO_BLINK: shadow_next.attr[ATTR_BLINK] = 1'b0;
							SGR_NO_REV: shadow_next.attr[ATTR_REVERSE] = 1'b0;
							SGR_FG_DEF: shadow_next.fg = 5'd0;
							SGR_BG_DEF: shadow_next.bg = 5'd0;
							[SGR_FG_BASE:SGR_FG_LAST]: shadow_next.fg = fg_norm[4:0];
							[SGR_BG_BASE:SGR_BG_LAST]: shadow_next.bg = bg_norm[4:0];
							[SGR_FGB_BASE:SGR_FGB_LAST]:
								shadow_next.fg = bright_colors ? fg_brt[4:0] : fg_fold[4:0];
							[SGR_BGB_BASE:SGR_BGB_LAST]:
								shadow_next.bg = bright_colors ? bg_brt[4:0] : bg_fold[4:0];
							default: ext_next.stopped = 1'b1;
						endcase
					end
				end
				EXT_WANT_SEP: begin
					if (is_semicolon) begin
						ext_next.phase = EXT_INDEX;
					end else begin
						stop = 1'b1;
					end
				end
				EXT_INDEX: begin
					// Palette index 0..15; anything larger ends the sequence's effect.
					if (param_value <= 16'd15) begin
						if (param_value <= 16'd7 || bright_colors) begin
							if (ext.is_bg) shadow_next.bg = ext_brt[4:0];
							else shadow_next.fg = ext_brt[4:0];
						end else begin
							if (ext.is_bg) shadow_next.bg = ext_fold[4:0];
							else shadow_next.fg = ext_fold[4:0];
						end
						ext_next.phase = EXT_NONE;
					end else begin
						stop = 1'b1;
					end
				end
				default: stop = 1'b1;
			endcase
			// A broken extended color drops the color it was setting.
			if (stop) begin
				if (ext_next.is_bg) shadow_next.bg = 5'd0;
				else shadow_next.fg = 5'd0;
				ext_next.stopped = 1'b1;
				ext_next.phase   = EXT_NONE;
			end
		end
	end

endmodule

// ----- hdl/asgr_parser.sv -----
`timescale 1ns / 1ps
// Escape-sequence parser: parse state, shadow and live attributes, result per byte.
// Depends on asgr_pkg and asgr_param_unit.
module asgr_parser #(
	parameter int unsigned MAX_SEQ = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              color_enable,
	input  logic              bright_colors,
	output asgr_pkg::result_t res
);
	import asgr_pkg::*;

	localparam int unsigned SEQ_W = $clog2(MAX_SEQ);
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(MAX_SEQ - 1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_ESC,
		MODE_CHARSET,
		MODE_CSI
	} mode_t;

	mode_t            mode_q, mode_d;
	logic             charset_q, charset_d;
	logic [15:0]      param_q, param_d;
	logic [SEQ_W-1:0] seq_len_q, seq_len_d;
	ext_state_t       ext_q, ext_d, ext_end;
	attr_set_t        shadow_q, shadow_d, shadow_end;
	attr_set_t        live_q, live_d;
	logic             text;

	logic        is_digit, is_semi;
	logic [3:0]  digit;
	logic [19:0] acc;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign is_semi  = (byte_in == CH_SEMI);
	assign digit    = 4'(byte_in - CH_ZERO);
	// param * 10 + digit, wide enough that it cannot wrap.
	assign acc = {1'b0, param_q, 3'b000} + {3'b000, param_q, 1'b0} + {16'd0, digit};

	asgr_param_unit u_param (
		.param_value   (param_q),
		.is_semicolon  (is_semi),
		.bright_colors (bright_colors),
		.shadow        (shadow_q),
		.ext           (ext_q),
		.shadow_next   (shadow_end),
		.ext_next      (ext_end)
	);

	// Next state for the byte on the input.
	always_comb begin
		mode_d    = mode_q;
		charset_d = charset_q;
		param_d   = param_q;
		seq_len_d = seq_len_q;
		ext_d     = ext_q;
		shadow_d  = shadow_q;
		live_d    = live_q;
		text      = 1'b0;
		case (mode_q)
			MODE_ESC: begin
				if (byte_in == CH_LBRACK) begin
					mode_d    = MODE_CSI;
					charset_d = 1'b0;
					shadow_d  = live_q;
					seq_len_d = '0;
					param_d   = '0;
					ext_d     = '0;
				end else if (byte_in == CH_LPAREN && !charset_q) begin
					mode_d    = MODE_CHARSET;
					charset_d = 1'b1;
				end else begin
					// Not a CSI: handle the byte as in text mode.
					mode_d    = MODE_IDLE;
					charset_d = 1'b0;
					if (byte_in == CH_ESC) begin
						if (color_enable) mode_d = MODE_ESC;
					end else begin
						text = 1'b1;
					end
				end
			end
			MODE_CHARSET: begin
				mode_d = MODE_ESC;
			end
			MODE_CSI: begin
				if (byte_in == CH_M) begin
					// Final byte: close the last parameter and commit.
					shadow_d = shadow_end;
					ext_d    = ext_end;
					live_d   = shadow_end;
					param_d  = '0;
					mode_d   = MODE_IDLE;
				end else if ((!is_digit && !is_semi) || seq_len_q >= SEQ_LAST) begin
					// Illegal or overlong: drop the sequence.
					mode_d = MODE_IDLE;
				end else begin
					seq_len_d = seq_len_q + 1'b1;
					if (is_semi) begin
						shadow_d = shadow_end;
						ext_d    = ext_end;
						param_d  = '0;
					end else if (!ext_q.stopped) begin
						if (ext_q.phase == EXT_WANT_5 && byte_in == CH_FIVE) begin
							ext_d.phase = EXT_WANT_SEP;
						end else if (ext_q.phase == EXT_WANT_5 || ext_q.phase == EXT_WANT_SEP) begin
							if (ext_q.is_bg) shadow_d.bg = 5'd0;
							else shadow_d.fg = 5'd0;
							ext_d.stopped = 1'b1;
							ext_d.phase   = EXT_NONE;
						end else begin
							param_d = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
						end
					end
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (byte_in == CH_ESC) begin
					if (color_enable) begin
						mode_d    = MODE_ESC;
						charset_d = 1'b0;
					end
				end else begin
					text = 1'b1;
				end
			end
		endcase
	end

	// Result for this byte, from the live set after the byte.
	always_comb begin
		res.text_valid = text;
		res.text_byte  = text ? byte_in : 8'd0;
		res.attr_bits  = live_d.attr;
		res.fg_index   = live_d.fg;
		res.bg_index   = live_d.bg;
		res.color_pair = (bright_colors ? {live_d.bg, 4'b0000}
			: ({1'b0, live_d.bg, 3'b000} + {4'b0000, live_d.bg}))
			+ {4'b0000, live_d.fg} + 9'd1;
	end

	// Parser state, advanced once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			charset_q <= 1'b0;
			param_q   <= '0;
			seq_len_q <= '0;
			ext_q     <= '0;
			shadow_q  <= '0;
			live_q    <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			charset_q <= charset_d;
			param_q   <= param_d;
			seq_len_q <= seq_len_d;
			ext_q     <= ext_d;
			shadow_q  <= shadow_d;
			live_q    <= live_d;
		end
	end

endmodule

// ----- hdl/asgr_out_stage.sv -----
`timescale 1ns / 1ps
// Output register with a skid entry, so the input side never waits on a taken beat.
// Depends on asgr_pkg for the result type.
module asgr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  asgr_pkg::result_t push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output asgr_pkg::result_t out_data
);
	import asgr_pkg::*;

	logic      main_v_q, skid_v_q;
	result_t   main_q, skid_q;
	logic      main_free;

	assign push_ready = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_data   = main_q;
	assign main_free  = !main_v_q || out_ready;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (main_free) begin
				main_v_q <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Payload: the skid entry drains first, a new beat never arrives with it full.
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- hdl/ansi_sgr_escape_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the SGR escape decoder: config registers, parser and output stage.
// Depends on asgr_pkg, asgr_if, asgr_parser and asgr_out_stage.
//
//   Channel   Dir   Fields                                              Beat
//   byte_ch   in    byte_in                                             one stream byte
//   res_ch    out   text_valid text_byte attr_bits fg_index bg_index    one result per byte
//                   color_pair
//   cfg_ch    in    index data                                          one register write
//
// One byte a cycle while byte_ch is not stalled: the parser updates its state from the
// accepted byte and the result is registered at the same edge, in the output register
// or in its skid entry.
// The output register has a skid entry; byte_ch stalls only when both are full.
// Reset puts the parser in text mode with default attributes; no clearing pass.
module ansi_sgr_escape_decoder_top #(
	parameter int unsigned MAX_SEQ = 100
) (
	input logic        clk,
	input logic        arst_n,
	asgr_byte_if.sink  byte_ch,
	asgr_res_if.source res_ch,
	asgr_cfg_if.sink   cfg_ch
);
	import asgr_pkg::*;

	logic    color_enable_q, bright_colors_q;
	logic    step, stage_ready;
	result_t res, out_res;

	// Configuration registers; writes are always taken.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_enable_q  <= 1'b0;
			bright_colors_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_COLOR_ENABLE: color_enable_q <= cfg_ch.data[0];
				CFG_BRIGHT_COLORS: bright_colors_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	assign byte_ch.ready = stage_ready;
	assign step          = byte_ch.valid && stage_ready;

	asgr_parser #(
		.MAX_SEQ (MAX_SEQ)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.byte_in       (byte_ch.byte_in),
		.color_enable  (color_enable_q),
		.bright_colors (bright_colors_q),
		.res           (res)
	);

	asgr_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (res),
		.push_ready (stage_ready),
		.out_valid  (res_ch.valid),
		.out_ready  (res_ch.ready),
		.out_data   (out_res)
	);

	// Result beat fields.
	assign res_ch.text_valid = out_res.text_valid;
	assign res_ch.text_byte  = out_res.text_byte;
	assign res_ch.attr_bits  = out_res.attr_bits;
	assign res_ch.fg_index   = out_res.fg_index;
	assign res_ch.bg_index   = out_res.bg_index;
	assign res_ch.color_pair = out_res.color_pair;

endmodule

// ----- tb/asgr_attr_checker.sv -----
`timescale 1ns / 1ps
// Checker for the SGR escape decoder: mirrors the parser on every accepted byte beat,
// queues the result beat that byte must produce and compares it with res_ch.
// Depends on asgr_pkg and the channel interfaces of asgr_if.
module asgr_attr_checker #(
	parameter int unsigned MAX_SEQ = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	asgr_byte_if        byte_ch,
	asgr_res_if         res_ch,
	asgr_cfg_if         cfg_ch,
	output int unsigned fail_count,
	output int unsigned pending_count
);
	import asgr_pkg::*;

	typedef enum logic [1:0] {
		PM_IDLE,
		PM_ESC,
		PM_CHARSET,
		PM_CSI
	} parse_mode_t;

	// Mirrored registers and parser state.
	logic         color_en;
	logic         bright;
	parse_mode_t  mode;
	logic         charset_skip;
	logic [15:0]  pval;
	logic [1:0]   ext_phase;
	logic         ext_bg;
	logic         stopped;
	logic [6:0]   seq_len;
	attr_set_t    shadow;
	attr_set_t    live;
	result_t      expected_results[$];
	int unsigned  mismatches;

	// A malformed or out-of-range extended color clears the color it targets.
	task automatic drop_ext_color();
		if (ext_bg)
			shadow.bg = '0;
		else
			shadow.fg = '0;
		stopped = 1'b1;
		ext_phase = EXT_NONE;
	endtask

	// Index of a 38;5;n or 48;5;n color.
	task automatic take_ext_index(input logic [15:0] n);
		logic [4:0] c;
		if (n > 16'd15) begin
			drop_ext_color();
		end else begin
			if (n <= 16'd7 || bright)
				c = n[4:0] + 5'd1;
			else
				c = n[4:0] - 5'd7;
			if (ext_bg)
				shadow.bg = c;
			else
				shadow.fg = c;
			ext_phase = EXT_NONE;
		end
	endtask

	// One plain SGR parameter applied to the shadow copy.
	task automatic apply_sgr(input logic [15:0] v);
		case (v)
			SGR_RESET: shadow = '0;
			SGR_BOLD: shadow.attr[ATTR_BOLD] = 1'b1;
			SGR_DIM: shadow.attr[ATTR_DIM] = 1'b1;
			SGR_ITALIC: shadow.attr[ATTR_ITALIC] = 1'b1;
			SGR_UNDERLINE: shadow.attr[ATTR_UNDERLINE] = 1'b1;
			SGR_BLINK: shadow.attr[ATTR_BLINK] = 1'b1;
			SGR_REVERSE: shadow.attr[ATTR_REVERSE] = 1'b1;
			SGR_NO_BOLD: shadow.attr[ATTR_BOLD] = 1'b0;
			SGR_NORMAL: begin
				shadow.attr[ATTR_BOLD] = 1'b0;
				shadow.attr[ATTR_DIM] = 1'b0;
			end
			SGR_NO_ITALIC: shadow.attr[ATTR_ITALIC] = 1'b0;
			SGR_NO_UNDER: shadow.attr[ATTR_UNDERLINE] = 1'b0;
			SGR_NO_BLINK: shadow.attr[ATTR_BLINK] = 1'b0;
			SGR_NO_REV: shadow.attr[ATTR_REVERSE] = 1'b0;
			SGR_FG_DEF: shadow.fg = '0;
			SGR_BG_DEF: shadow.bg = '0;
			default: begin
				if (v >= SGR_FG_BASE && v <= SGR_FG_LAST)
					shadow.fg = 5'(v - SGR_FG_BASE + 1);
				else if (v >= SGR_BG_BASE && v <= SGR_BG_LAST)
					shadow.bg = 5'(v - SGR_BG_BASE + 1);
				else if (v >= SGR_FGB_BASE && v <= SGR_FGB_LAST)
					shadow.fg = 5'(v - SGR_FGB_BASE + (bright ? 9 : 1));
				else if (v >= SGR_BGB_BASE && v <= SGR_BGB_LAST)
					shadow.bg = 5'(v - SGR_BGB_BASE + (bright ? 9 : 1));
				else
					stopped = 1'b1;
			end
		endcase
	endtask

	// A ';' or the final 'm' closes the parameter collected so far.
	task automatic close_param(input logic is_semi);
		if (!stopped) begin
			case (ext_phase)
				EXT_NONE: begin
					if (pval == SGR_FG_EXT || pval == SGR_BG_EXT) begin
						ext_bg = (pval == SGR_BG_EXT);
						if (is_semi)
							ext_phase = EXT_WANT_5;
						else
							drop_ext_color();
					end else begin
						apply_sgr(pval);
					end
				end
				EXT_WANT_SEP: begin
					if (is_semi)
						ext_phase = EXT_INDEX;
					else
						drop_ext_color();
				end
				EXT_INDEX: take_ext_index(pval);
				default: drop_ext_color();
			endcase
		end
		pval = '0;
	endtask

	// One byte inside ESC [ ... m.
	task automatic csi_step(input logic [7:0] b);
		logic        is_digit;
		int unsigned acc;
		is_digit = (b >= CH_ZERO && b <= CH_NINE);
		if (b == CH_M) begin
			close_param(1'b0);
			live = shadow;
			mode = PM_IDLE;
		end else if (!is_digit && b != CH_SEMI) begin
			mode = PM_IDLE;
		end else if (seq_len >= MAX_SEQ - 1) begin
			mode = PM_IDLE;
		end else begin
			seq_len = seq_len + 7'd1;
			if (b == CH_SEMI) begin
				close_param(1'b1);
			end else if (!stopped) begin
				if (ext_phase == EXT_WANT_5) begin
					if (b == CH_FIVE)
						ext_phase = EXT_WANT_SEP;
					else
						drop_ext_color();
				end else if (ext_phase == EXT_WANT_SEP) begin
					drop_ext_color();
				end else begin
					acc = pval * 10 + (b - CH_ZERO);
					pval = (acc > 65535) ? 16'hFFFF : acc[15:0];
				end
			end
		end
	endtask

	// Text mode: ESC opens an escape when decoding is on, anything else is text.
	task automatic pass_text(input logic [7:0] b, output logic text);
		text = (b != CH_ESC);
		if (b == CH_ESC && color_en) begin
			mode = PM_ESC;
			charset_skip = 1'b0;
		end
	endtask

	// Advances the mirrored parser by one byte and forms the result it must emit.
	task automatic predict_result(input logic [7:0] b, output result_t r);
		logic text;
		text = 1'b0;
		case (mode)
			PM_ESC: begin
				if (b == CH_LBRACK) begin
					mode = PM_CSI;
					charset_skip = 1'b0;
					shadow = live;
					seq_len = '0;
					pval = '0;
					ext_phase = EXT_NONE;
					ext_bg = 1'b0;
					stopped = 1'b0;
				end else if (b == CH_LPAREN && !charset_skip) begin
					mode = PM_CHARSET;
					charset_skip = 1'b1;
				end else begin
					mode = PM_IDLE;
					charset_skip = 1'b0;
					pass_text(b, text);
				end
			end
			PM_CHARSET: mode = PM_ESC;
			PM_CSI: csi_step(b);
			default: pass_text(b, text);
		endcase
		r.text_valid = text;
		r.text_byte = text ? b : 8'h00;
		r.attr_bits = live.attr;
		r.fg_index = live.fg;
		r.bg_index = live.bg;
		r.color_pair = 9'(live.bg * (bright ? 16 : 9) + live.fg + 1);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Results are checked before the byte of the same edge is predicted, since a
	// result beat always belongs to a byte accepted at an earlier edge.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			color_en = 1'b0;
			bright = 1'b0;
			mode = PM_IDLE;
			charset_skip = 1'b0;
			pval = '0;
			ext_phase = EXT_NONE;
			ext_bg = 1'b0;
			stopped = 1'b0;
			seq_len = '0;
			shadow = '0;
			live = '0;
			mismatches = 0;
			expected_results.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.text_valid = res_ch.text_valid;
				got.text_byte = res_ch.text_byte;
				got.attr_bits = res_ch.attr_bits;
				got.fg_index = res_ch.fg_index;
				got.bg_index = res_ch.bg_index;
				got.color_pair = res_ch.color_pair;
				if (expected_results.size() == 0) begin
					$error("result beat with no byte waiting for it");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("text_valid", want.text_valid, got.text_valid);
					check_field("text_byte", want.text_byte, got.text_byte);
					check_field("attr_bits", want.attr_bits, got.attr_bits);
					check_field("fg_index", want.fg_index, got.fg_index);
					check_field("bg_index", want.bg_index, got.bg_index);
					check_field("color_pair", want.color_pair, got.color_pair);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == CFG_COLOR_ENABLE)
					color_en = cfg_ch.data[0];
				else if (cfg_ch.index == CFG_BRIGHT_COLORS)
					bright = cfg_ch.data[0];
			end
			if (byte_ch.valid && byte_ch.ready) begin
				predict_result(byte_ch.byte_in, want);
				expected_results.push_back(want);
			end
			fail_count <= mismatches;
			pending_count <= expected_results.size();
		end
	end

endmodule

// ----- tb/tb_ansi_sgr_escape_decoder_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the SGR escape decoder: clock, reset, byte stream and register
// writes under varying gaps and stalls, and the verdict.
// Depends on asgr_pkg, asgr_if, the decoder RTL and asgr_attr_checker.
module tb_ansi_sgr_escape_decoder_top;
	import asgr_pkg::*;

	localparam int unsigned MAX_SEQ = 100;
	localparam int unsigned RANDOM_BYTES = 760;
	localparam int unsigned NUM_PHASES = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Register settings per random phase, bit i for phase i.
	localparam logic [NUM_PHASES-1:0] ENABLE_PLAN = 8'b1101_1011;
	localparam logic [NUM_PHASES-1:0] BRIGHT_PLAN = 8'b0101_0101;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned sgr_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	asgr_byte_if byte_ch();
	asgr_res_if  res_ch();
	asgr_cfg_if  cfg_ch();

	ansi_sgr_escape_decoder_top #(
		.MAX_SEQ(MAX_SEQ)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.res_ch(res_ch),
		.cfg_ch(cfg_ch)
	);

	asgr_attr_checker #(
		.MAX_SEQ(MAX_SEQ)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.res_ch(res_ch),
		.cfg_ch(cfg_ch),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	always #5 clk = ~clk;

	// Result side stalls at the rate of the current phase.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				pending_count);
			$display("status: fail");
			$finish;
		end
	end

	// Valid stays high after a beat so back-to-back beats never lower and raise it
	// in one step; it drops only in a gap or when the stream pauses.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Decimal parameter, now and then with a leading zero.
	task automatic send_number(input int unsigned v);
		if ($urandom_range(7) == 0)
			send_byte(CH_ZERO);
		send_str($sformatf("%0d", v));
	endtask

	// Pause the stream and wait until every result has come back.
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers in one burst; bit 0 carries the setting.
	task automatic write_config(input logic enable, input logic bright);
		logic [CFG_DAT_W-1:0] d;
		d = CFG_DAT_W'($urandom);
		d[0] = enable;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_COLOR_ENABLE;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		d = CFG_DAT_W'($urandom);
		d[0] = bright;
		cfg_ch.index <= CFG_BRIGHT_COLORS;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic int unsigned pick_sgr_code();
		int unsigned v;
		case ($urandom_range(9))
			0: v = $urandom_range(7);
			1, 2: v = $urandom_range(21, 27);
			3: v = $urandom_range(30, 39);
			4: v = $urandom_range(40, 49);
			5: v = $urandom_range(90, 97);
			6: v = $urandom_range(100, 107);
			7: v = $urandom_range(8, 120);
			8: v = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(65536, 999999);
			default: v = $urandom_range(1, 5);
		endcase
		return v;
	endfunction

	// 38;5;n or 48;5;n; the broken forms stop the parameter list.
	task automatic send_ext_color(input logic clean);
		int unsigned form;
		form = clean ? 0 : $urandom_range(1, 3);
		send_number($urandom_range(1) ? SGR_BG_EXT : SGR_FG_EXT);
		case (form)
			0: begin
				send_byte(CH_SEMI);
				send_byte(CH_FIVE);
				send_byte(CH_SEMI);
				if ($urandom_range(7) == 0)
					send_number($urandom_range(16, 300));
				else if ($urandom_range(7) != 0)
					send_number($urandom_range(15));
			end
			1: ;
			2: begin
				send_byte(CH_SEMI);
				send_number($urandom_range(99));
			end
			default: begin
				send_byte(CH_SEMI);
				send_byte(CH_FIVE);
			end
		endcase
	endtask

	task automatic send_param(input logic clean);
		int unsigned k;
		k = $urandom_range(9);
		if (k == 1 || k == 2)
			send_ext_color(clean);
		else if (k != 0)
			send_number(pick_sgr_code());
	endtask

	// ESC [ params m, optionally behind a charset prefix; a broken one ends in an
	// illegal byte or carries a malformed extended color.
	task automatic send_sgr(input logic clean);
		int unsigned nparam;
		logic [7:0]  b;
		send_byte(CH_ESC);
		if ($urandom_range(4) == 0) begin
			send_byte(CH_LPAREN);
			send_byte(8'($urandom_range(255)));
		end
		send_byte(CH_LBRACK);
		nparam = $urandom_range(4);
		for (int i = 0; i < nparam; i++) begin
			if (i != 0)
				send_byte(CH_SEMI);
			send_param(clean);
		end
		if (clean || $urandom_range(1) == 0) begin
			send_byte(CH_M);
		end else begin
			do
				b = 8'($urandom_range(255));
			while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_M);
			send_byte(b);
		end
		sgr_sent++;
	endtask

	// ESC [ with a body of digits and separators, then 'm'.
	task automatic send_long_sgr(input int unsigned body);
		send_byte(CH_ESC);
		send_byte(CH_LBRACK);
		for (int i = 0; i < body; i++)
			send_byte(8'(($urandom_range(3) == 0) ? CH_SEMI : CH_ZERO + $urandom_range(9)));
		send_byte(CH_M);
	endtask

	task automatic send_random_chunk();
		case ($urandom_range(19))
			9, 10: send_sgr(1'b0);
			11: begin
				send_byte(CH_ESC);
				send_byte(8'($urandom_range(255)));
			end
			12, 13: begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
			end
			14: begin
				send_byte(CH_ESC);
				send_byte(CH_LPAREN);
				send_byte(8'($urandom_range(255)));
				send_byte(($urandom_range(1) == 0) ? CH_LPAREN : CH_ESC);
			end
			default: send_sgr(1'b1);
		endcase
	endtask

	initial begin
		int unsigned phase_end;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decoding is off after reset: ESC is dropped and the rest is text.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_ESC);
		send_str("[1m");
		drain();
		write_config(1'b1, 1'b1);

		send_byte(CH_ESC);
		send_str("[1;91;107mA");
		// Charset prefix followed by a fresh ESC before the '['.
		send_byte(CH_ESC);
		send_str("(B");
		send_byte(CH_ESC);
		send_str("[38;5;15m");
		// A second '(' after the skipped charset byte is plain text.
		send_byte(CH_ESC);
		send_str("(x(");
		// Unsupported code: the underline before it still commits, the blink after does not.
		send_byte(CH_ESC);
		send_str("[4;99;5mx");
		// Illegal byte aborts and discards the bold.
		send_byte(CH_ESC);
		send_str("[1;Q");
		send_byte(CH_ESC);
		send_str("[48;5;16m");
		send_byte(CH_ESC);
		send_str("[38;5;m");
		send_byte(CH_ESC);
		send_str("[2;3;5;7;22;23;27;24;25;21m");
		send_byte(CH_ESC);
		send_str("[999999m");
		send_byte(CH_ESC);
		send_str("[m");
		// Longest body that fits, then one byte too many.
		send_long_sgr(MAX_SEQ - 1);
		send_long_sgr(MAX_SEQ);
		// Register write in the middle of a sequence; the bright color mapping
		// follows the setting in force when each parameter closes.
		send_byte(CH_ESC);
		send_str("[91;9");
		drain();
		write_config(1'b1, 1'b0);
		send_str("1mz");
		drain();

		// Random phases: settings and flow control change between them.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					send_idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			write_config(ENABLE_PLAN[p], BRIGHT_PLAN[p]);
			phase_end = bytes_sent + RANDOM_BYTES / NUM_PHASES;
			while (bytes_sent < phase_end)
				send_random_chunk();
			drain();
		end

		$display("sent %0d stream bytes (%0d SGR sequences) over %0d register settings",
			bytes_sent, sgr_sent, NUM_PHASES + 2);
		$display("with free flow, sender gaps, result stalls and both together");
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/asgr_pkg.sv
hdl/asgr_if.sv
hdl/asgr_param_unit.sv
hdl/asgr_parser.sv
hdl/asgr_out_stage.sv
hdl/ansi_sgr_escape_decoder_top.sv
tb/asgr_attr_checker.sv
tb/tb_ansi_sgr_escape_decoder_top.sv
